[design/fps_pkg.sv]
// Shared types, constants and the control store for the Fenwick range-sum block.
package fps_pkg;

  // Default number of positions and the fixed field widths.
  localparam int unsigned SizeDef = 1024;
  localparam int unsigned PosW    = 11;
  localparam int unsigned ValW    = 32;
  localparam int unsigned SumW    = 42;

  // Request command codes.
  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Microprogram step labels; the step counter holds one of these.
  typedef enum logic [3:0] {
    S_CLEAR     = 4'd0,
    S_IDLE      = 4'd1,
    S_SET_RD    = 4'd2,
    S_SET_DELTA = 4'd3,
    S_UP_RD     = 4'd4,
    S_UP_WR     = 4'd5,
    S_PH_RD     = 4'd6,
    S_PH_ACC    = 4'd7,
    S_PL_INIT   = 4'd8,
    S_PL_RD     = 4'd9,
    S_PL_ACC    = 4'd10,
    S_OUT       = 4'd11
  } step_e;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_CLR    = 4'd1,
    OP_LOAD   = 4'd2,
    OP_DELTA  = 4'd3,
    OP_UP     = 4'd4,
    OP_ADD    = 4'd5,
    OP_SUB    = 4'd6,
    OP_LOLOAD = 4'd7,
    OP_OUT    = 4'd8
  } op_e;

  // Branch conditions; the true target is taken when the condition holds.
  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_START    = 3'd1,
    COND_CLR_DONE = 3'd2,
    COND_UP_END   = 3'd3,
    COND_DN_END   = 3'd4,
    COND_LO_ZERO  = 3'd5
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic  pt_we;
    logic  tr_we;
    op_e   op;
    cond_e cond;
    step_e nxt_t;
    step_e nxt_f;
  } uword_t;

  // Read-only control store: one word per step.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      S_CLEAR:     w = '{1'b1, 1'b1, OP_CLR,    COND_CLR_DONE, S_IDLE,      S_CLEAR};
      S_IDLE:      w = '{1'b0, 1'b0, OP_LOAD,   COND_START,    S_IDLE,      S_IDLE};
      S_SET_RD:    w = '{1'b0, 1'b0, OP_NONE,   COND_ALWAYS,   S_SET_DELTA, S_SET_DELTA};
      S_SET_DELTA: w = '{1'b1, 1'b0, OP_DELTA,  COND_ALWAYS,   S_UP_RD,     S_UP_RD};
      S_UP_RD:     w = '{1'b0, 1'b0, OP_NONE,   COND_ALWAYS,   S_UP_WR,     S_UP_WR};
      S_UP_WR:     w = '{1'b0, 1'b1, OP_UP,     COND_UP_END,   S_IDLE,      S_UP_RD};
      S_PH_RD:     w = '{1'b0, 1'b0, OP_NONE,   COND_ALWAYS,   S_PH_ACC,    S_PH_ACC};
      S_PH_ACC:    w = '{1'b0, 1'b0, OP_ADD,    COND_DN_END,   S_PL_INIT,   S_PH_RD};
      S_PL_INIT:   w = '{1'b0, 1'b0, OP_LOLOAD, COND_LO_ZERO,  S_OUT,       S_PL_RD};
      S_PL_RD:     w = '{1'b0, 1'b0, OP_NONE,   COND_ALWAYS,   S_PL_ACC,    S_PL_ACC};
      S_PL_ACC:    w = '{1'b0, 1'b0, OP_SUB,    COND_DN_END,   S_OUT,       S_PL_RD};
      S_OUT:       w = '{1'b0, 1'b0, OP_OUT,    COND_ALWAYS,   S_IDLE,      S_IDLE};
      default:     w = '{1'b0, 1'b0, OP_NONE,   COND_ALWAYS,   S_IDLE,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/fps_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module fps_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/fenwick_point_set_range_sum.sv]
// Fenwick tree with point set and range sum, run by a microcoded sequencer.
//
// A request is taken when start_i is high and busy_o is low. A set request
// (command 0) walks the tree nodes on the upward path from the position (at
// most log2(Size)+1 of them); a set at position zero or beyond Size changes
// nothing. A query request (command 1) walks one tree node for each set bit
// of range_high and of range_low-1; an empty range goes straight to the
// output step. Every tree node takes a read step and then an update or
// accumulate step, because both memories share one address and have a
// registered read. Each query gives exactly one result: range_sum_o is
// valid for the single cycle in which result_valid_o is high and cannot be
// held off, so the receiver must take it then. A set gives no result. After
// reset the block clears every address of both memories with busy_o high
// before it takes its first request.
module fenwick_point_set_range_sum
  import fps_pkg::*;
#(
  parameter int unsigned Size = SizeDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   command_i,
  input  logic [PosW-1:0]        position_i,
  input  logic signed [ValW-1:0] new_value_i,
  input  logic [PosW-1:0]        range_low_i,
  input  logic [PosW-1:0]        range_high_i,
  output logic                   result_valid_o,
  output logic signed [SumW-1:0] range_sum_o
);

  localparam int unsigned AW = $clog2(Size);
  localparam int unsigned IW = AW + 2;
  localparam logic [IW-1:0] SizeI = IW'(Size);
  localparam logic [AW-1:0] LastA = AW'(Size - 1);
  localparam logic [31:0]   Size32 = 32'(Size);

  step_e              step_q, step_d;
  uword_t             uw;
  logic [IW-1:0]      idx_q, idx_d;
  logic [IW-1:0]      lo_q, lo_d;
  logic [ValW-1:0]    val_q, val_d;
  logic [SumW-1:0]    delta_q, delta_d;
  logic [SumW-1:0]    acc_q, acc_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic               valid_q, valid_d;
  logic [SumW-1:0]    sum_q, sum_d;

  logic [31:0]        pos_w, hi_w, lo_w, hi_sat_w, lo_adj_w;
  logic               set_ok, q_empty, clearing;
  logic [IW-1:0]      idx_lb, idx_up, idx_dn, idx_m1;
  logic [AW-1:0]      ram_addr;
  logic [ValW-1:0]    pt_rdata, pt_wdata;
  logic [SumW-1:0]    tr_rdata, tr_wdata;
  logic [SumW-1:0]    val_ext, old_ext;

  // Current control word from the control store.
  assign uw       = ucode(step_q);
  assign clearing = (uw.op == OP_CLR);

  // Request decode: range checks and the saturated query bounds.
  assign pos_w    = 32'(position_i);
  assign hi_w     = 32'(range_high_i);
  assign lo_w     = 32'(range_low_i);
  assign set_ok   = (pos_w != 32'd0) && (pos_w <= Size32);
  assign hi_sat_w = (hi_w > Size32) ? Size32 : hi_w;
  assign lo_adj_w = (lo_w == 32'd0) ? 32'd1 : lo_w;
  assign q_empty  = (lo_adj_w > hi_sat_w);

  // Index arithmetic: lowest set bit, upward and downward neighbors.
  assign idx_lb = idx_q & (~idx_q + IW'(1));
  assign idx_up = idx_q + idx_lb;
  assign idx_dn = idx_q - idx_lb;
  assign idx_m1 = idx_q - IW'(1);

  // Both memories share one address: the clear counter or the walk index less one.
  assign ram_addr = clearing ? clr_q : idx_m1[AW-1:0];
  assign pt_wdata = clearing ? '0 : val_q;
  assign tr_wdata = clearing ? '0 : (tr_rdata + delta_q);

  assign val_ext = {{(SumW-ValW){val_q[ValW-1]}}, val_q};
  assign old_ext = {{(SumW-ValW){pt_rdata[ValW-1]}}, pt_rdata};

  fps_ram #(
    .Width (ValW),
    .Depth (Size)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (uw.pt_we),
    .waddr_i (ram_addr),
    .wdata_i (pt_wdata),
    .raddr_i (ram_addr),
    .rdata_o (pt_rdata)
  );

  fps_ram #(
    .Width (SumW),
    .Depth (Size)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (uw.tr_we),
    .waddr_i (ram_addr),
    .wdata_i (tr_wdata),
    .raddr_i (ram_addr),
    .rdata_o (tr_rdata)
  );

  // Step counter: sequencing with conditional jumps and request dispatch.
  always_comb begin
    step_d = uw.nxt_f;
    case (uw.cond)
      COND_ALWAYS: begin
        step_d = uw.nxt_t;
      end
      COND_START: begin
        if (!start_i) begin
          step_d = S_IDLE;
        end else if (command_i == CMD_SET) begin
          step_d = set_ok ? S_SET_RD : S_IDLE;
        end else begin
          step_d = q_empty ? S_OUT : S_PH_RD;
        end
      end
      COND_CLR_DONE: step_d = (clr_q == LastA) ? uw.nxt_t : uw.nxt_f;
      COND_UP_END:   step_d = (idx_up > SizeI) ? uw.nxt_t : uw.nxt_f;
      COND_DN_END:   step_d = (idx_dn == '0) ? uw.nxt_t : uw.nxt_f;
      COND_LO_ZERO:  step_d = (lo_q == '0) ? uw.nxt_t : uw.nxt_f;
      default:       step_d = S_IDLE;
    endcase
  end

  // Datapath operations selected by the control word.
  always_comb begin
    idx_d   = idx_q;
    lo_d    = lo_q;
    val_d   = val_q;
    delta_d = delta_q;
    acc_d   = acc_q;
    clr_d   = clr_q;
    valid_d = 1'b0;
    sum_d   = sum_q;
    case (uw.op)
      OP_CLR: begin
        clr_d = clr_q + AW'(1);
      end
      OP_LOAD: begin
        if (start_i) begin
          val_d = new_value_i;
          acc_d = '0;
          if (command_i == CMD_SET) begin
            idx_d = IW'(pos_w);
          end else begin
            idx_d = IW'(hi_sat_w);
            lo_d  = IW'(lo_adj_w - 32'd1);
          end
        end
      end
      OP_DELTA: begin
        delta_d = val_ext - old_ext;
      end
      OP_UP: begin
        idx_d = idx_up;
      end
      OP_ADD: begin
        acc_d = acc_q + tr_rdata;
        idx_d = idx_dn;
      end
      OP_SUB: begin
        acc_d = acc_q - tr_rdata;
        idx_d = idx_dn;
      end
      OP_LOLOAD: begin
        idx_d = lo_q;
      end
      OP_OUT: begin
        valid_d = 1'b1;
        sum_d   = acc_q;
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= S_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    lo_q    <= lo_d;
    val_q   <= val_d;
    delta_q <= delta_d;
    acc_q   <= acc_d;
    sum_q   <= sum_d;
  end

  assign busy_o         = (step_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign range_sum_o    = sum_q;

  // A result only follows the output step.
  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(step_q == S_OUT))
    else $error("result strobe without an output step");

  // Results are never on two consecutive cycles.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // The update walk only writes tree nodes inside the position range.
  a_update_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_UP_WR) |-> ((idx_q != '0) && (idx_q <= SizeI)))
    else $error("tree update outside the position range");

  // The prefix walks never accumulate at index zero.
  a_prefix_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((step_q == S_PH_ACC) || (step_q == S_PL_ACC)) |-> (idx_q != '0))
    else $error("prefix walk at index zero");

endmodule

[verif/fenwick_point_set_range_sum_tb.sv]
// Self-checking testbench for the Fenwick point-set, range-sum block.
module fenwick_point_set_range_sum_tb;
  import fps_pkg::*;

  localparam int unsigned Size = SizeDef;
  localparam int RandomItems  = 630;
  localparam int CycleLimit   = 400000;
  localparam int DrainCycles  = 60;
  localparam int PrintCap     = 40;
  localparam int DirectedRows = 23;

  // One row of directed stimulus; known marks a query whose sum is typed in.
  typedef struct {
    cmd_e                   cmd;
    logic [PosW-1:0]        pos;
    logic signed [ValW-1:0] value;
    logic [PosW-1:0]        lo;
    logic [PosW-1:0]        hi;
    bit                     known;
    logic signed [SumW-1:0] sum;
  } stim_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start_i;
  logic                   busy_o;
  logic                   command_i;
  logic [PosW-1:0]        position_i;
  logic signed [ValW-1:0] new_value_i;
  logic [PosW-1:0]        range_low_i;
  logic [PosW-1:0]        range_high_i;
  logic                   result_valid_o;
  logic signed [SumW-1:0] range_sum_o;

  // Shadow copy of the tree, the stored values and the sums still to come.
  logic [SumW-1:0]        node_sums [1:Size];
  logic signed [ValW-1:0] stored_vals [1:Size];
  logic signed [SumW-1:0] pending_sums [$];
  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  int                     burst_left = 0;

  // Directed requests: empty tree, extremes, ignored sets and edge ranges.
  stim_row_t directed_rows [DirectedRows] = '{
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1,    11'd1024, 1'b1, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd0,    11'd2047, 1'b1, 42'sd0},
    '{CMD_SET,   11'd1,    32'h7FFF_FFFF, 11'd0,   11'd0,    1'b0, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1,    11'd1,    1'b1, 42'sd2147483647},
    '{CMD_SET,   11'd1024, 32'h8000_0000, 11'd0,   11'd0,    1'b0, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1024, 11'd1024, 1'b1, -42'sd2147483648},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd0,    11'd2047, 1'b1, -42'sd1},
    '{CMD_SET,   11'd0,    32'sd12345,   11'd0,    11'd0,    1'b0, 42'sd0},
    '{CMD_SET,   11'd1025, 32'sd777,     11'd0,    11'd0,    1'b0, 42'sd0},
    '{CMD_SET,   11'd2047, 32'hFFFF_FFFF, 11'd0,   11'd0,    1'b0, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd0,    11'd2047, 1'b1, -42'sd1},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd5,    11'd3,    1'b1, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd2047, 11'd2047, 1'b1, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1025, 11'd2000, 1'b1, 42'sd0},
    '{CMD_SET,   11'd512,  32'hFFFF_FFFF, 11'd0,   11'd0,    1'b0, 42'sd0},
    '{CMD_SET,   11'd1,    32'sd0,       11'd0,    11'd0,    1'b0, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1,    11'd1024, 1'b0, 42'sd0},
    '{CMD_SET,   11'd1023, 32'h7FFF_FFFF, 11'd0,   11'd0,    1'b0, 42'sd0},
    '{CMD_SET,   11'd768,  32'h8000_0000, 11'd0,   11'd0,    1'b0, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd512,  11'd1023, 1'b0, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1,    11'd1,    1'b1, 42'sd0},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd1024, 11'd2047, 1'b1, -42'sd2147483648},
    '{CMD_QUERY, 11'd0,    32'sd0,       11'd513,  11'd1024, 1'b0, 42'sd0}
  };

  // Free-running clock, 8 time units per period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  fenwick_point_set_range_sum i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .position_i     (position_i),
    .new_value_i    (new_value_i),
    .range_low_i    (range_low_i),
    .range_high_i   (range_high_i),
    .result_valid_o (result_valid_o),
    .range_sum_o    (range_sum_o)
  );

  // Prints one line per mismatch, up to a cap, and counts every one.
  task automatic report_mismatch(string what, logic signed [SumW-1:0] got,
                                 logic signed [SumW-1:0] want);
    if (mismatch_count < PrintCap) begin
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic int unsigned lowest_bit(int unsigned idx);
    return idx & (~idx + 1);
  endfunction

  // Replaces the value at one position and pushes the change up the tree.
  task automatic store_value(logic [PosW-1:0] pos, logic signed [ValW-1:0] value);
    logic signed [SumW-1:0] fresh;
    logic signed [SumW-1:0] prior;
    logic [SumW-1:0]        change;
    int unsigned            idx;
    if (pos == 0 || pos > Size) return;
    fresh  = SumW'(value);
    prior  = SumW'(stored_vals[pos]);
    change = fresh - prior;
    stored_vals[pos] = value;
    idx = 32'(pos);
    while (idx <= Size) begin
      node_sums[idx] = node_sums[idx] + change;
      idx = idx + lowest_bit(idx);
    end
  endtask

  // Sum of positions 1..upto by the downward walk.
  function automatic logic [SumW-1:0] prefix_total(int unsigned upto);
    logic [SumW-1:0] acc;
    int unsigned     idx;
    acc = '0;
    idx = upto;
    while (idx > 0 && idx <= Size) begin
      acc = acc + node_sums[idx];
      idx = idx - lowest_bit(idx);
    end
    return acc;
  endfunction

  // Range sum with the low end raised to one and the high end held to Size.
  function automatic logic signed [SumW-1:0] range_total(logic [PosW-1:0] lo,
                                                         logic [PosW-1:0] hi);
    int unsigned lo_pos;
    int unsigned hi_pos;
    lo_pos = (lo == 0) ? 1 : 32'(lo);
    hi_pos = (hi > Size) ? Size : 32'(hi);
    if (lo_pos > hi_pos) return '0;
    return prefix_total(hi_pos) - prefix_total(lo_pos - 1);
  endfunction

  // Updates the shadow state for one accepted request.
  task automatic predict_request(cmd_e cmd, logic [PosW-1:0] pos,
                                 logic signed [ValW-1:0] value,
                                 logic [PosW-1:0] lo, logic [PosW-1:0] hi);
    if (cmd == CMD_SET) begin
      store_value(pos, value);
    end else begin
      pending_sums = {pending_sums, range_total(lo, hi)};
    end
  endtask

  // Idle length before the next request: mostly none, sometimes long.
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drives one request and returns at the edge where it is accepted.
  task automatic issue_request(cmd_e cmd, logic [PosW-1:0] pos,
                               logic signed [ValW-1:0] value,
                               logic [PosW-1:0] lo, logic [PosW-1:0] hi);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i      <= 1'b1;
    command_i    <= cmd;
    position_i   <= pos;
    new_value_i  <= value;
    range_low_i  <= lo;
    range_high_i <= hi;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Holds requests back until every pending sum has come out.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_sums.size() != 0) @(posedge clk_i);
  endtask

  // Compares each range sum with the oldest pending one.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_sums.size() == 0) begin
        report_mismatch("range sum with no query pending", range_sum_o, '0);
      end else begin
        if (range_sum_o !== pending_sums[0]) begin
          report_mismatch("range sum", range_sum_o, pending_sums[0]);
        end
        void'(pending_sums.pop_front());
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Reset, directed table, then random requests.
  initial begin
    int                     useful;
    int                     roll;
    cmd_e                   cmd;
    logic [PosW-1:0]        pos;
    logic [PosW-1:0]        lo;
    logic [PosW-1:0]        hi;
    logic [PosW-1:0]        a;
    logic [PosW-1:0]        b;
    logic signed [ValW-1:0] value;

    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    command_i    <= CMD_SET;
    position_i   <= '0;
    new_value_i  <= '0;
    range_low_i  <= '0;
    range_high_i <= '0;
    for (int unsigned k = 1; k <= Size; k++) begin
      node_sums[k]   = '0;
      stored_vals[k] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: typed sums where obvious, the predictor elsewhere.
    foreach (directed_rows[n]) begin
      issue_request(directed_rows[n].cmd, directed_rows[n].pos, directed_rows[n].value,
                    directed_rows[n].lo, directed_rows[n].hi);
      if (directed_rows[n].known) begin
        pending_sums = {pending_sums, directed_rows[n].sum};
      end else begin
        predict_request(directed_rows[n].cmd, directed_rows[n].pos,
                        directed_rows[n].value, directed_rows[n].lo, directed_rows[n].hi);
      end
    end
    drain_results();

    // Random part; ignored sets do not count toward the total.
    useful = 0;
    while (useful < RandomItems) begin
      cmd   = ($urandom_range(0, 99) < 50) ? CMD_SET : CMD_QUERY;
      pos   = PosW'($urandom);
      value = $urandom;
      lo    = PosW'($urandom);
      hi    = PosW'($urandom);
      if (cmd == CMD_SET) begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          pos = ($urandom_range(0, 1) == 0) ? '0 : PosW'($urandom_range(Size + 1, 2047));
        end else if (roll < 20) begin
          pos = PosW'($urandom_range(1, 16));
        end else if (roll < 30) begin
          pos = PosW'($urandom_range(Size - 15, Size));
        end else begin
          pos = PosW'($urandom_range(1, Size));
        end
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          case ($urandom_range(0, 3))
            0:       value = 32'h7FFF_FFFF;
            1:       value = 32'h8000_0000;
            2:       value = '1;
            default: value = '0;
          endcase
        end else if (roll < 40) begin
          value = $urandom_range(0, 200);
          value = value - 100;
        end
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          lo = PosW'($urandom_range(0, 1));
          hi = PosW'($urandom_range(Size, 2047));
        end else if (roll >= 25) begin
          a  = PosW'($urandom_range(1, Size));
          b  = PosW'($urandom_range(1, Size));
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
        end
      end
      issue_request(cmd, pos, value, lo, hi);
      predict_request(cmd, pos, value, lo, hi);
      if (!(cmd == CMD_SET && (pos == 0 || pos > Size))) useful++;
      if ($urandom_range(0, 149) == 0) drain_results();
    end

    // Let the last query come out, then give the block time to settle.
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
